/* rtl/htw_pkg.sv */
// shared types and constants of the hierarchical timer wheel
package htw_pkg;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 6;
  localparam int IVAL_W = 31;
  localparam int TICK_W = 32;
  localparam int LINK_W = 7;

  localparam logic [LINK_W-1:0] NIL = 7'h7F;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LATCH,
    OP_ARM,
    OP_UL_RD,
    OP_UL_WR,
    OP_PEND_CLR,
    OP_PL_RD,
    OP_PL_WR1,
    OP_PL_WR2,
    OP_HEAD_RD,
    OP_DETACH,
    OP_WALK_RD,
    OP_FIRE,
    OP_REPL,
    OP_NEXT,
    OP_ADV,
    OP_NEXT_LVL,
    OP_FLUSH
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_UL_RD,
    ST_UL_WR,
    ST_ARM,
    ST_PEND_CLR,
    ST_PL_RD,
    ST_PL_WR1,
    ST_PL_WR2,
    ST_HEAD_RD,
    ST_DETACH,
    ST_WALK_CHK,
    ST_EVAL,
    ST_NEXT,
    ST_LVL_END,
    ST_WRAP_CHK
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic             clr_last;
    logic [CMD_W-1:0] cmd;
    logic             id_ok;
    logic             pend;
    logic             tail_nil;
    logic             t_nil;
    logic             is_due;
    logic             rpt;
    logic             lvl0;
    logic             lvl4;
    logic             wrap;
  } dp_stat_t;

endpackage

/* rtl/hierarchical_timer_wheel.sv */
// Five-level hierarchical timer wheel with 64-entry timer table and command interface.
// After reset the block clears its 2^FAST_BITS + 4*2^SLOW_BITS bucket heads and tails,
// one bucket per cycle, with busy high. An add first unlinks the timer if it was pending,
// then arms it and appends it to its target bucket, with one more link write when that
// bucket already holds a timer; a delete unlinks a pending timer and clears its pending
// bit, and does nothing for an idle timer. A tick drains the current fast bucket and,
// on each wrap, the current bucket of the next slow level, firing due timers, re-arming
// periodic ones and re-placing the rest; each list walk step is one access of the bucket
// and link memories. Expired timer ids come out one per transfer on out_valid, held for
// one cycle only; the receiver cannot stall them; out_last marks the final one of a tick.
module hierarchical_timer_wheel #(
  parameter int FAST_BITS   = 8,
  parameter int SLOW_BITS   = 6,
  parameter int TIMER_COUNT = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [htw_pkg::CMD_W-1:0]  in_command,
  input  logic [htw_pkg::ID_W-1:0]   in_timer_id,
  input  logic [htw_pkg::IVAL_W-1:0] in_interval,
  input  logic                       in_periodic,
  output logic                       out_valid,
  output logic [htw_pkg::ID_W-1:0]   out_expired_id,
  output logic                       out_last
);

  htw_pkg::dp_cmd_t  dp_cmd;
  htw_pkg::dp_stat_t dp_stat;

  htw_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd_o  (dp_cmd),
    .stat_i (dp_stat)
  );

  htw_datapath #(
    .FAST_BITS   (FAST_BITS),
    .SLOW_BITS   (SLOW_BITS),
    .TIMER_COUNT (TIMER_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .in_command     (in_command),
    .in_timer_id    (in_timer_id),
    .in_interval    (in_interval),
    .in_periodic    (in_periodic),
    .out_valid      (out_valid),
    .out_expired_id (out_expired_id),
    .out_last       (out_last)
  );

endmodule

/* rtl/htw_datapath.sv */
// timer wheel datapath: bucket lists, timer records, wheel positions, result register
module htw_datapath #(
  parameter int FAST_BITS   = 8,
  parameter int SLOW_BITS   = 6,
  parameter int TIMER_COUNT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  htw_pkg::dp_cmd_t              cmd_i,
  output htw_pkg::dp_stat_t             stat_o,
  input  logic [htw_pkg::CMD_W-1:0]     in_command,
  input  logic [htw_pkg::ID_W-1:0]      in_timer_id,
  input  logic [htw_pkg::IVAL_W-1:0]    in_interval,
  input  logic                          in_periodic,
  output logic                          out_valid,
  output logic [htw_pkg::ID_W-1:0]      out_expired_id,
  output logic                          out_last
);

  localparam int FAST_SIZE = 1 << FAST_BITS;
  localparam int SLOW_SIZE = 1 << SLOW_BITS;
  localparam int BUCKETS   = FAST_SIZE + 4 * SLOW_SIZE;
  localparam int BW        = $clog2(BUCKETS);
  localparam int TW        = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int LW        = htw_pkg::LINK_W;

  // memories
  logic [LW-1:0]                 head_mem [BUCKETS];
  logic [LW-1:0]                 tail_mem [BUCKETS];
  logic [LW-1:0]                 next_mem [TIMER_COUNT];
  logic [LW-1:0]                 prev_mem [TIMER_COUNT];
  logic [BW-1:0]                 home_mem [TIMER_COUNT];
  logic [htw_pkg::TICK_W-1:0]    due_mem  [TIMER_COUNT];
  logic [htw_pkg::IVAL_W-1:0]    per_mem  [TIMER_COUNT];
  logic                          rpt_mem  [TIMER_COUNT];

  logic [LW-1:0]                 head_q, tail_q, next_q, prev_q;
  logic [BW-1:0]                 home_q;
  logic [htw_pkg::TICK_W-1:0]    due_q;
  logic [htw_pkg::IVAL_W-1:0]    per_q;
  logic                          rpt_q;

  // registers
  logic [htw_pkg::CMD_W-1:0]     cmd_r;
  logic                          per_r;
  logic [htw_pkg::IVAL_W-1:0]    ival_r;
  logic [LW-1:0]                 t_r, nx_r;
  logic [htw_pkg::IVAL_W-1:0]    d_r;
  logic [BW-1:0]                 b_r;
  logic [2:0]                    lvl_r;
  logic                          wrap_r;
  logic [htw_pkg::TICK_W-1:0]    tick_r;
  logic [FAST_BITS-1:0]          pos0_r;
  logic [SLOW_BITS-1:0]          posk_r [4];
  logic [BW-1:0]                 clr_r;
  logic [TIMER_COUNT-1:0]        pending_r;
  logic                          hold_v_r;
  logic [htw_pkg::ID_W-1:0]      hold_id_r;
  logic                          out_valid_r;
  logic [htw_pkg::ID_W-1:0]      out_id_r;
  logic                          out_last_r;

  // write and read ports
  logic                          head_we, tail_we, next_we, prev_we, home_we, due_we, rec_we;
  logic [BW-1:0]                 head_wa, tail_wa;
  logic [LW-1:0]                 head_wd, tail_wd, next_wd, prev_wd;
  logic [TW-1:0]                 next_wa, prev_wa;
  logic [htw_pkg::TICK_W-1:0]    due_wd;
  logic                          head_re, tail_re, ul_re, walk_re;
  logic [BW-1:0]                 head_ra, tail_ra;

  logic [TW-1:0]                 t_idx;
  logic [1:0]                    lvl_m1;
  logic [BW-1:0]                 drain_b, place_b;
  logic [FAST_BITS-1:0]          fast_idx;
  logic [htw_pkg::TICK_W-1:0]    diff_c, due_new, fdiff;
  logic [htw_pkg::IVAL_W-1:0]    fire_d;
  logic                          id_ok;

  assign t_idx   = t_r[TW-1:0];
  assign lvl_m1  = 2'(lvl_r - 3'd1);
  assign id_ok   = (t_r < LW'(TIMER_COUNT));
  assign drain_b = (lvl_r == 3'd0) ? BW'(pos0_r)
                 : BW'(FAST_SIZE) + (BW'(lvl_m1) << SLOW_BITS) + BW'(posk_r[lvl_m1]);

  assign diff_c  = due_q - tick_r;
  assign due_new = due_q + {1'b0, per_q};
  assign fdiff   = due_new - tick_r;

  // rearm distance: negative clamps to zero, fast drain needs at least one
  always_comb begin
    fire_d = fdiff[31] ? '0 : fdiff[htw_pkg::IVAL_W-1:0];
    if (lvl_r == 3'd0 && fire_d == '0) begin
      fire_d = htw_pkg::IVAL_W'(1);
    end
  end

  assign fast_idx = d_r[FAST_BITS-1:0] + pos0_r;

  // bucket choice by distance
  always_comb begin
    logic                 found;
    logic [SLOW_BITS-1:0] idx;
    found   = 1'b0;
    idx     = '0;
    place_b = BW'(fast_idx);
    if ((d_r >> FAST_BITS) != '0) begin
      for (int k = 0; k < 4; k++) begin
        if (!found && (k == 3 || (d_r >> (FAST_BITS + (k + 1) * SLOW_BITS)) == '0)) begin
          idx     = SLOW_BITS'(d_r >> (FAST_BITS + k * SLOW_BITS)) - 1'b1 + posk_r[k];
          place_b = BW'(FAST_SIZE) + BW'(k << SLOW_BITS) + BW'(idx);
          found   = 1'b1;
        end
      end
    end
  end

  // port steering per micro operation
  always_comb begin
    head_we = 1'b0; head_wa = drain_b; head_wd = htw_pkg::NIL;
    tail_we = 1'b0; tail_wa = drain_b; tail_wd = htw_pkg::NIL;
    next_we = 1'b0; next_wa = t_idx;   next_wd = htw_pkg::NIL;
    prev_we = 1'b0; prev_wa = t_idx;   prev_wd = tail_q;
    home_we = 1'b0;
    due_we  = 1'b0; due_wd = due_new;
    rec_we  = 1'b0;
    head_re = 1'b0; head_ra = drain_b;
    tail_re = 1'b0; tail_ra = place_b;
    ul_re   = 1'b0;
    walk_re = 1'b0;
    case (cmd_i.op)
      htw_pkg::OP_CLR: begin
        head_we = 1'b1; head_wa = clr_r;
        tail_we = 1'b1; tail_wa = clr_r;
      end
      htw_pkg::OP_ARM: begin
        due_we = 1'b1; due_wd = tick_r + {1'b0, ival_r};
        rec_we = 1'b1;
      end
      htw_pkg::OP_UL_RD: ul_re = 1'b1;
      htw_pkg::OP_UL_WR: begin
        if (prev_q == htw_pkg::NIL) begin
          head_we = 1'b1; head_wa = home_q; head_wd = next_q;
        end else begin
          next_we = 1'b1; next_wa = prev_q[TW-1:0]; next_wd = next_q;
        end
        if (next_q == htw_pkg::NIL) begin
          tail_we = 1'b1; tail_wa = home_q; tail_wd = prev_q;
        end else begin
          prev_we = 1'b1; prev_wa = next_q[TW-1:0]; prev_wd = prev_q;
        end
      end
      htw_pkg::OP_PL_RD: tail_re = 1'b1;
      htw_pkg::OP_PL_WR1: begin
        home_we = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        tail_we = 1'b1; tail_wa = b_r; tail_wd = t_r;
        if (tail_q == htw_pkg::NIL) begin
          head_we = 1'b1; head_wa = b_r; head_wd = t_r;
        end
      end
      htw_pkg::OP_PL_WR2: begin
        next_we = 1'b1; next_wa = tail_q[TW-1:0]; next_wd = t_r;
      end
      htw_pkg::OP_HEAD_RD: head_re = 1'b1;
      htw_pkg::OP_DETACH: begin
        head_we = 1'b1;
        tail_we = 1'b1;
      end
      htw_pkg::OP_WALK_RD: walk_re = 1'b1;
      htw_pkg::OP_FIRE: due_we = rpt_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (tail_re) tail_q <= tail_mem[tail_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (ul_re || walk_re) next_q <= next_mem[t_idx];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (ul_re) prev_q <= prev_mem[t_idx];
  end

  always_ff @(posedge clk) begin
    if (home_we) home_mem[t_idx] <= b_r;
    if (ul_re) home_q <= home_mem[t_idx];
  end

  always_ff @(posedge clk) begin
    if (due_we) due_mem[t_idx] <= due_wd;
    if (walk_re) due_q <= due_mem[t_idx];
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      per_mem[t_idx] <= ival_r;
      rpt_mem[t_idx] <= per_r;
    end
    if (walk_re) begin
      per_q <= per_mem[t_idx];
      rpt_q <= rpt_mem[t_idx];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd_i.op)
      htw_pkg::OP_LATCH: begin
        cmd_r  <= in_command;
        t_r    <= LW'(in_timer_id);
        ival_r <= (in_interval == '0) ? htw_pkg::IVAL_W'(1) : in_interval;
        per_r  <= in_periodic;
      end
      htw_pkg::OP_ARM:    d_r <= ival_r;
      htw_pkg::OP_PL_RD:  b_r <= place_b;
      htw_pkg::OP_DETACH: t_r <= head_q;
      htw_pkg::OP_FIRE: begin
        nx_r <= next_q;
        d_r  <= fire_d;
      end
      htw_pkg::OP_REPL: begin
        nx_r <= next_q;
        d_r  <= diff_c[htw_pkg::IVAL_W-1:0];
      end
      htw_pkg::OP_NEXT:   t_r <= nx_r;
      default: ;
    endcase
  end

  // control state of the wheel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      pending_r   <= '0;
      tick_r      <= '0;
      pos0_r      <= '0;
      posk_r      <= '{default: '0};
      lvl_r       <= '0;
      wrap_r      <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (cmd_i.op)
        htw_pkg::OP_CLR:      clr_r <= clr_r + 1'b1;
        htw_pkg::OP_LATCH:    lvl_r <= '0;
        htw_pkg::OP_ARM:      pending_r[t_idx] <= 1'b1;
        htw_pkg::OP_PEND_CLR: pending_r[t_idx] <= 1'b0;
        htw_pkg::OP_DETACH: begin
          if (lvl_r != 3'd0) begin
            posk_r[lvl_m1] <= posk_r[lvl_m1] + 1'b1;
            wrap_r         <= &posk_r[lvl_m1];
          end
        end
        htw_pkg::OP_FIRE: begin
          if (!rpt_q) pending_r[t_idx] <= 1'b0;
          // one result held back so the last one of a tick can be flagged
          if (hold_v_r) begin
            out_valid_r <= 1'b1;
            out_id_r    <= hold_id_r;
            out_last_r  <= 1'b0;
          end
          hold_v_r  <= 1'b1;
          hold_id_r <= t_r[htw_pkg::ID_W-1:0];
        end
        htw_pkg::OP_ADV: begin
          pos0_r <= pos0_r + 1'b1;
          tick_r <= tick_r + 1'b1;
          wrap_r <= &pos0_r;
        end
        htw_pkg::OP_NEXT_LVL: lvl_r <= lvl_r + 3'd1;
        htw_pkg::OP_FLUSH: begin
          if (hold_v_r) begin
            out_valid_r <= 1'b1;
            out_id_r    <= hold_id_r;
            out_last_r  <= 1'b1;
          end
          hold_v_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.clr_last = (clr_r == BW'(BUCKETS - 1));
  assign stat_o.cmd      = cmd_r;
  assign stat_o.id_ok    = id_ok;
  assign stat_o.pend     = id_ok && pending_r[t_idx];
  assign stat_o.tail_nil = (tail_q == htw_pkg::NIL);
  assign stat_o.t_nil    = (t_r == htw_pkg::NIL);
  assign stat_o.is_due   = (diff_c == '0) || diff_c[31];
  assign stat_o.rpt      = rpt_q;
  assign stat_o.lvl0     = (lvl_r == 3'd0);
  assign stat_o.lvl4     = (lvl_r == 3'd4);
  assign stat_o.wrap     = wrap_r;

  assign out_valid      = out_valid_r;
  assign out_expired_id = out_id_r;
  assign out_last       = out_last_r;

endmodule

/* rtl/htw_ctrl.sv */
// timer wheel controller: sequences list operations, tick drains and cascades
module htw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output htw_pkg::dp_cmd_t  cmd_o,
  input  htw_pkg::dp_stat_t stat_i
);

  htw_pkg::ctl_state_t state_r, state_nxt;
  logic ctx_walk_r, ctx_walk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= htw_pkg::ST_CLEAR;
      ctx_walk_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ctx_walk_r <= ctx_walk_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ctx_walk_nxt = ctx_walk_r;
    cmd_o.op     = htw_pkg::OP_NONE;
    case (state_r)
      htw_pkg::ST_CLEAR: begin
        cmd_o.op = htw_pkg::OP_CLR;
        if (stat_i.clr_last) state_nxt = htw_pkg::ST_IDLE;
      end
      htw_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.op  = htw_pkg::OP_LATCH;
          state_nxt = htw_pkg::ST_DECODE;
        end
      end
      htw_pkg::ST_DECODE: begin
        case (stat_i.cmd)
          htw_pkg::CMD_TICK: state_nxt = htw_pkg::ST_HEAD_RD;
          htw_pkg::CMD_ADD: begin
            if (!stat_i.id_ok)    state_nxt = htw_pkg::ST_IDLE;
            else if (stat_i.pend) state_nxt = htw_pkg::ST_UL_RD;
            else                  state_nxt = htw_pkg::ST_ARM;
          end
          htw_pkg::CMD_DEL: begin
            if (stat_i.pend) state_nxt = htw_pkg::ST_UL_RD;
            else             state_nxt = htw_pkg::ST_IDLE;
          end
          default: state_nxt = htw_pkg::ST_IDLE;
        endcase
      end
      htw_pkg::ST_UL_RD: begin
        cmd_o.op  = htw_pkg::OP_UL_RD;
        state_nxt = htw_pkg::ST_UL_WR;
      end
      htw_pkg::ST_UL_WR: begin
        cmd_o.op  = htw_pkg::OP_UL_WR;
        state_nxt = (stat_i.cmd == htw_pkg::CMD_ADD) ? htw_pkg::ST_ARM : htw_pkg::ST_PEND_CLR;
      end
      htw_pkg::ST_PEND_CLR: begin
        cmd_o.op  = htw_pkg::OP_PEND_CLR;
        state_nxt = htw_pkg::ST_IDLE;
      end
      htw_pkg::ST_ARM: begin
        cmd_o.op     = htw_pkg::OP_ARM;
        ctx_walk_nxt = 1'b0;
        state_nxt    = htw_pkg::ST_PL_RD;
      end
      htw_pkg::ST_PL_RD: begin
        cmd_o.op  = htw_pkg::OP_PL_RD;
        state_nxt = htw_pkg::ST_PL_WR1;
      end
      htw_pkg::ST_PL_WR1: begin
        cmd_o.op = htw_pkg::OP_PL_WR1;
        if (!stat_i.tail_nil) state_nxt = htw_pkg::ST_PL_WR2;
        else if (ctx_walk_r)  state_nxt = htw_pkg::ST_NEXT;
        else                  state_nxt = htw_pkg::ST_IDLE;
      end
      htw_pkg::ST_PL_WR2: begin
        cmd_o.op  = htw_pkg::OP_PL_WR2;
        state_nxt = ctx_walk_r ? htw_pkg::ST_NEXT : htw_pkg::ST_IDLE;
      end
      htw_pkg::ST_HEAD_RD: begin
        cmd_o.op  = htw_pkg::OP_HEAD_RD;
        state_nxt = htw_pkg::ST_DETACH;
      end
      htw_pkg::ST_DETACH: begin
        cmd_o.op  = htw_pkg::OP_DETACH;
        state_nxt = htw_pkg::ST_WALK_CHK;
      end
      htw_pkg::ST_WALK_CHK: begin
        if (stat_i.t_nil) begin
          state_nxt = htw_pkg::ST_LVL_END;
        end else begin
          cmd_o.op  = htw_pkg::OP_WALK_RD;
          state_nxt = htw_pkg::ST_EVAL;
        end
      end
      htw_pkg::ST_EVAL: begin
        ctx_walk_nxt = 1'b1;
        // fast slot entries always fire, cascaded ones only when due
        if (stat_i.lvl0 || stat_i.is_due) begin
          cmd_o.op  = htw_pkg::OP_FIRE;
          state_nxt = stat_i.rpt ? htw_pkg::ST_PL_RD : htw_pkg::ST_NEXT;
        end else begin
          cmd_o.op  = htw_pkg::OP_REPL;
          state_nxt = htw_pkg::ST_PL_RD;
        end
      end
      htw_pkg::ST_NEXT: begin
        cmd_o.op  = htw_pkg::OP_NEXT;
        state_nxt = htw_pkg::ST_WALK_CHK;
      end
      htw_pkg::ST_LVL_END: begin
        if (stat_i.lvl0) cmd_o.op = htw_pkg::OP_ADV;
        state_nxt = htw_pkg::ST_WRAP_CHK;
      end
      htw_pkg::ST_WRAP_CHK: begin
        if (stat_i.wrap && !stat_i.lvl4) begin
          cmd_o.op  = htw_pkg::OP_NEXT_LVL;
          state_nxt = htw_pkg::ST_HEAD_RD;
        end else begin
          cmd_o.op  = htw_pkg::OP_FLUSH;
          state_nxt = htw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = htw_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r != htw_pkg::ST_IDLE);

endmodule

/* rtl/htw_checker.sv */
// port-level checks of the timer wheel, bound to the top level
module htw_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [htw_pkg::CMD_W-1:0] in_command,
  input logic                      out_valid,
  input logic                      out_last
);

  // a result that is not the last of its tick comes while the tick is running
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result outside a tick");

  // the last result ends the burst
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after the last one");

  // add, delete and unknown commands give no result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command != htw_pkg::CMD_TICK |=> !out_valid)
    else $error("result after a non-tick command");

  // an accepted transfer keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("not busy after accepting a command");

endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_command (in_command),
  .out_valid  (out_valid),
  .out_last   (out_last)
);
